// ----- rtl/alu_pkg.sv -----
// ----------------------------------------------------------------------------
// ALU package
// Operation codes, transfer payload types and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package alu_pkg;

   localparam int unsigned DataWidth = 32;

   typedef enum logic [4:0] {
      OP_ADD  = 5'd0,
      OP_SUB  = 5'd1,
      OP_MUL  = 5'd2,
      OP_HMUL = 5'd3,
      OP_DIV  = 5'd4,
      OP_MOD  = 5'd5,
      OP_LDIV = 5'd6,
      OP_AND  = 5'd7,
      OP_NAND = 5'd8,
      OP_OR   = 5'd9,
      OP_XOR  = 5'd10,
      OP_NOT  = 5'd11,
      OP_TEST = 5'd12,
      OP_LSHF = 5'd13,
      OP_RSHF = 5'd14,
      OP_LROT = 5'd15,
      OP_RROT = 5'd16
   } op_type;

   typedef struct packed {
      logic [4:0]  req_type;
      logic [31:0] operand_a;
      logic [31:0] operand_b;
      logic        use_carry;
   } req_type_t_type;

   typedef struct packed {
      logic [31:0] result;
      logic        carry_flag;
      logic        borrow_flag;
      logic        overflow_flag;
      logic        zero_flag;
      logic        negative_flag;
      logic        odd_flag;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/alu_with_status_flags_top.sv -----
// ----------------------------------------------------------------------------
// ALU with status flags
// Bit-serial 32-bit ALU keeping carry, borrow, overflow, zero, negative and
// odd flags.
// ----------------------------------------------------------------------------
// One operation is handled at a time. Operations are worked through shift
// registers one step per cycle. Add, subtract, the logic operations and test
// pass one operand bit per cycle through a single-bit slice. Multiply uses 32
// shift-and-add steps on a 64-bit accumulator. Divide and modulo use 32
// restoring-division steps, and long divide uses 64, one quotient bit per
// step. Multiply and divide each use a 33-bit adder per step. Shifts and
// rotates step a rotating window 32 times and move it only while the step
// count is below the shift count. The result is registered on the last step
// of the run state and offered in the done state, where it is held while
// the receiver stalls. The request side stalls from the accepting transfer
// until the cycle after the result transfer completes. Undefined operation
// codes give a zero result and leave every flag untouched.
// ----------------------------------------------------------------------------
`default_nettype none

module alu_with_status_flags_top
   import alu_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output      logic           req_stall,
   input  wire req_type_t_type req_data,
   output      logic           rsp_valid,
   input  wire logic           rsp_stall,
   output      rsp_type        rsp_data
);

   state_type   state_ff, state_in;
   logic [4:0]  op_ff;
   logic [31:0] a_ff, a_in;          // operand shift register
   logic [31:0] b_ff, b_in;          // second operand / divisor
   logic [63:0] acc_ff, acc_in;      // product, remainder or result window
   logic [31:0] q_ff, q_in;          // quotient or serial result
   logic [6:0]  cnt_ff, cnt_in;
   logic        cy_ff, cy_in;        // serial carry or borrow
   logic        c_ff, bw_ff, v_ff, z_ff, n_ff, o_ff;
   logic [31:0] res_ff;
   logic        accept, last;
   logic [6:0]  steps;
   logic        ab, bb, sb, co;
   logic [32:0] rem_try;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

   // Step count for the operation in hand.
   always_comb begin
      case (op_ff)
         OP_LDIV: steps = 7'd64;
         default: steps = 7'd32;
      endcase
   end
   assign last = (cnt_ff == steps - 7'd1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_RUN;
         ST_RUN:  if (last) state_in = ST_DONE;
         ST_DONE: if (!rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Serial datapath: one bit of the operation per cycle.
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff + 7'd1;
      cy_in   = cy_ff;
      ab      = a_ff[0];
      bb      = b_ff[0];
      sb      = 1'b0;
      co      = 1'b0;
      rem_try = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
         end
         ST_RUN: begin
            case (op_ff)
               OP_ADD, OP_SUB: begin
                  if (op_ff == OP_SUB) begin
                     sb = ab ^ bb ^ cy_ff;
                     co = (!ab && (bb || cy_ff)) || (bb && cy_ff);
                  end else begin
                     sb = ab ^ bb ^ cy_ff;
                     co = (ab && bb) || (cy_ff && (ab ^ bb));
                  end
                  cy_in = co;
                  a_in  = {ab, a_ff[31:1]};   // keeps a intact for overflow
                  b_in  = {bb, b_ff[31:1]};
                  q_in  = {sb, q_ff[31:1]};
               end
               OP_MUL, OP_HMUL: begin
                  acc_in = acc_ff;
                  if (a_ff[0]) acc_in[63:31] = {1'b0, acc_ff[63:32]} + {1'b0, b_ff};
                  else acc_in[63:31] = {1'b0, acc_ff[63:32]};
                  acc_in[30:0] = acc_ff[31:1];
                  a_in = {1'b0, a_ff[31:1]};
               end
               OP_DIV, OP_MOD, OP_LDIV: begin
                  // Restoring division: dividend bits enter from a_ff's top.
                  rem_try = {acc_ff[31:0], a_ff[31]} - {1'b0, b_ff};
                  a_in    = {a_ff[30:0], 1'b0};
                  if (!rem_try[32]) acc_in[32:0] = rem_try;
                  else acc_in[32:0] = {acc_ff[31:0], a_ff[31]};
                  acc_in[63:33] = '0;
                  q_in = {q_ff[30:0], !rem_try[32]};
               end
               OP_LSHF, OP_RSHF, OP_LROT, OP_RROT: begin
                  // acc holds the rotating window; step it while cnt < count.
                  if (cnt_ff < {2'b00, b_ff[4:0]}) begin
                     case (op_ff)
                        OP_LSHF: acc_in[31:0] = {acc_ff[30:0], 1'b0};
                        OP_RSHF: acc_in[31:0] = {1'b0, acc_ff[31:1]};
                        OP_LROT: acc_in[31:0] = {acc_ff[30:0], acc_ff[31]};
                        default: acc_in[31:0] = {acc_ff[0], acc_ff[31:1]};
                     endcase
                  end
               end
               default: begin
                  case (op_ff)
                     OP_AND:  sb = ab & bb;
                     OP_NAND: sb = !(ab & bb);
                     OP_OR:   sb = ab | bb;
                     OP_XOR:  sb = ab ^ bb;
                     OP_NOT:  sb = !ab;
                     OP_TEST: sb = ab;
                     default: sb = 1'b0;
                  endcase
                  a_in = {ab, a_ff[31:1]};
                  b_in = {bb, b_ff[31:1]};
                  q_in = {sb, q_ff[31:1]};
               end
            endcase
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   // Result selection from the values that the final step produces. With a
   // zero divisor every trial subtraction leaves the shifted value, so the
   // remainder register ends up holding the dividend.
   logic [31:0] fin;
   logic        valid_op;
   always_comb begin
      valid_op = (op_ff <= OP_RROT);
      case (op_ff)
         OP_MUL:  fin = acc_in[31:0];
         OP_HMUL: fin = acc_in[63:32];
         OP_DIV, OP_LDIV: fin = (b_ff == '0) ? '1 : q_in;
         OP_MOD:  fin = acc_in[31:0];
         OP_LSHF, OP_RSHF, OP_LROT, OP_RROT: fin = acc_in[31:0];
         default: fin = valid_op ? q_in : '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         c_ff <= 1'b0; bw_ff <= 1'b0; v_ff <= 1'b0;
         z_ff <= 1'b0; n_ff <= 1'b0; o_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (state_ff == ST_RUN && last && valid_op) begin
            z_ff <= (fin == '0);
            n_ff <= fin[31];
            o_ff <= fin[0];
            if (op_ff == OP_ADD) begin
               c_ff <= cy_in;
               v_ff <= !(a_in[31] ^ b_in[31]) & (a_in[31] ^ q_in[31]);
            end
            if (op_ff == OP_SUB) begin
               bw_ff <= cy_in;
               v_ff  <= (a_in[31] ^ b_in[31]) & (a_in[31] ^ q_in[31]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_data.req_type;
         b_ff   <= req_data.operand_b;
         q_ff   <= '0;
         a_ff   <= req_data.operand_a;
         if (req_data.req_type == OP_LSHF || req_data.req_type == OP_RSHF ||
             req_data.req_type == OP_LROT || req_data.req_type == OP_RROT)
            acc_ff <= {32'd0, req_data.operand_a};
         else acc_ff <= '0;
         if (req_data.req_type == OP_ADD) cy_ff <= c_ff & req_data.use_carry;
         else cy_ff <= bw_ff & req_data.use_carry;
      end else if (state_ff == ST_RUN) begin
         // Long divide: after 32 dividend bits, zeros follow (a_ff shifts in 0).
         a_ff   <= a_in;
         b_ff   <= b_in;
         acc_ff <= acc_in;
         q_ff   <= q_in;
         cy_ff  <= cy_in;
         if (last) res_ff <= fin;
      end
   end

   assign rsp_data.result        = res_ff;
   assign rsp_data.carry_flag    = c_ff;
   assign rsp_data.borrow_flag   = bw_ff;
   assign rsp_data.overflow_flag = v_ff;
   assign rsp_data.zero_flag     = z_ff;
   assign rsp_data.negative_flag = n_ff;
   assign rsp_data.odd_flag      = o_ff;

endmodule

`default_nettype wire

// ----- rtl/alu_checker.sv -----
// ----------------------------------------------------------------------------
// ALU port checker
// Watches the transfer ports of the ALU top level.
// ----------------------------------------------------------------------------
`default_nettype none

module alu_checker
   import alu_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // While a result is offered, the request side stalls, so no request is taken.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken while result offered");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.zero_flag == (rsp_data.result == '0)) ||
                    (rsp_data.result == '0))
      else $error("zero flag disagrees with result");

   a_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !req_stall)
      else $error("not ready after result transfer");

endmodule

bind alu_with_status_flags_top alu_checker u_alu_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);

`default_nettype wire

// ----- dv/tb_alu_with_status_flags_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ALU with status flags testbench
// Drives directed and random operations through the request channel, predicts
// result and flags with a behavioural flag model, and compares every response
// transfer in order, under varying idle patterns on both sides.
// ----------------------------------------------------------------------------
module tb_alu_with_status_flags_top;
   import alu_pkg::*;

   logic           clock;
   logic           reset;
   logic           req_valid;
   logic           req_stall;
   req_type_t_type req_data;
   logic           rsp_valid;
   logic           rsp_stall;
   rsp_type        rsp_data;

   alu_with_status_flags_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   localparam int NumRandom  = 1100;
   localparam int CycleLimit = 400000;

   // Flag state held by the predictor, mirroring the block's status register.
   logic fl_carry, fl_borrow, fl_overflow, fl_zero, fl_negative, fl_odd;

   rsp_type   pending_rsp[$];
   int        failures;
   int        cycle_count;
   int        send_idle_pct;
   int        recv_idle_pct;

   // One row of the directed table; has_exp marks rows whose response is typed
   // in by hand rather than left to the predictor.
   typedef struct {
      req_type_t_type req;
      bit             has_exp;
      rsp_type        exp;
   } dir_row_type;

   dir_row_type dir_table[$];

   function automatic logic [31:0] rotate_left(logic [31:0] v, logic [4:0] n);
      return (n == 0) ? v : ((v << n) | (v >> (6'd32 - n)));
   endfunction

   // Computes the response to one operation and advances the flag state.
   function automatic rsp_type alu_predict(req_type_t_type rq);
      logic [32:0] sum;
      logic [32:0] sub;
      logic [63:0] prod;
      logic [31:0] a, b, r;
      logic        known;
      rsp_type     o;
      a     = rq.operand_a;
      b     = rq.operand_b;
      r     = '0;
      known = 1'b1;
      prod  = {32'd0, a} * {32'd0, b};
      case (rq.req_type)
         OP_ADD: begin
            sum = {1'b0, a} + {1'b0, b} + {32'd0, fl_carry & rq.use_carry};
            r = sum[31:0];
            fl_carry = sum[32];
            fl_overflow = ~(a[31] ^ b[31]) & (a[31] ^ r[31]);
         end
         OP_SUB: begin
            sub = {1'b0, b} + {32'd0, fl_borrow & rq.use_carry};
            r = a - sub[31:0];
            fl_borrow = ({1'b0, a} < sub);
            fl_overflow = (a[31] ^ b[31]) & (a[31] ^ r[31]);
         end
         OP_MUL:  r = prod[31:0];
         OP_HMUL: r = prod[63:32];
         OP_DIV:  r = (b == 0) ? '1 : a / b;
         OP_MOD:  r = (b == 0) ? a : a % b;
         OP_LDIV: r = (b == 0) ? '1 : 32'(({a, 32'd0}) / {32'd0, b});
         OP_AND:  r = a & b;
         OP_NAND: r = ~(a & b);
         OP_OR:   r = a | b;
         OP_XOR:  r = a ^ b;
         OP_NOT:  r = ~a;
         OP_TEST: r = a;
         OP_LSHF: r = a << b[4:0];
         OP_RSHF: r = a >> b[4:0];
         OP_LROT: r = rotate_left(a, b[4:0]);
         OP_RROT: r = rotate_left(a, 5'(6'd32 - b[4:0]));
         default: known = 1'b0;
      endcase
      if (known) begin
         fl_zero = (r == 0);
         fl_negative = r[31];
         fl_odd = r[0];
      end
      o.result = r;
      o.carry_flag = fl_carry;
      o.borrow_flag = fl_borrow;
      o.overflow_flag = fl_overflow;
      o.zero_flag = fl_zero;
      o.negative_flag = fl_negative;
      o.odd_flag = fl_odd;
      return o;
   endfunction

   function automatic req_type_t_type mk_req(logic [4:0] op, logic [31:0] a,
                                             logic [31:0] b, logic uc);
      req_type_t_type rq;
      rq.req_type = op;
      rq.operand_a = a;
      rq.operand_b = b;
      rq.use_carry = uc;
      return rq;
   endfunction

   function automatic rsp_type mk_rsp(logic [31:0] r, logic [5:0] flags);
      rsp_type o;
      o.result = r;
      {o.carry_flag, o.borrow_flag, o.overflow_flag,
       o.zero_flag, o.negative_flag, o.odd_flag} = flags;
      return o;
   endfunction

   task automatic add_row(req_type_t_type rq, bit has, rsp_type ex);
      dir_row_type row;
      row.req = rq;
      row.has_exp = has;
      row.exp = ex;
      dir_table.push_back(row);
   endtask

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Cycle counter acting as a watchdog for a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // The receiver stalls at random according to the current phase's rate.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Response checker: every transfer is compared with the oldest prediction.
   always @(posedge clock) begin
      rsp_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected response transfer, result %h", rsp_data.result);
            failures++;
         end else begin
            exp = pending_rsp.pop_front();
            if (rsp_data.result !== exp.result) begin
               $error("result: expected %h, actual %h", exp.result, rsp_data.result);
               failures++;
            end
            if (rsp_data.carry_flag !== exp.carry_flag) begin
               $error("carry_flag: expected %b, actual %b",
                      exp.carry_flag, rsp_data.carry_flag);
               failures++;
            end
            if (rsp_data.borrow_flag !== exp.borrow_flag) begin
               $error("borrow_flag: expected %b, actual %b",
                      exp.borrow_flag, rsp_data.borrow_flag);
               failures++;
            end
            if (rsp_data.overflow_flag !== exp.overflow_flag) begin
               $error("overflow_flag: expected %b, actual %b",
                      exp.overflow_flag, rsp_data.overflow_flag);
               failures++;
            end
            if (rsp_data.zero_flag !== exp.zero_flag) begin
               $error("zero_flag: expected %b, actual %b",
                      exp.zero_flag, rsp_data.zero_flag);
               failures++;
            end
            if (rsp_data.negative_flag !== exp.negative_flag) begin
               $error("negative_flag: expected %b, actual %b",
                      exp.negative_flag, rsp_data.negative_flag);
               failures++;
            end
            if (rsp_data.odd_flag !== exp.odd_flag) begin
               $error("odd_flag: expected %b, actual %b",
                      exp.odd_flag, rsp_data.odd_flag);
               failures++;
            end
         end
      end
   end

   // Presents one request, idling first at the sender's current rate, and
   // holds it until the transfer completes. Valid is dropped only when the
   // sender idles, so back-to-back requests keep it high. The prediction is
   // queued at the accepting edge, so it always precedes the matching response.
   task automatic send_op(req_type_t_type rq, bit has_exp, rsp_type typed);
      rsp_type pred;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (req_stall);
      pred = alu_predict(rq);
      // Hand-typed rows must agree with the predictor as well as the block.
      if (has_exp && pred !== typed) begin
         $error("result: expected %h, actual %h (typed row vs prediction)",
                typed.result, pred.result);
         failures++;
      end
      pending_rsp.push_back(pred);
   endtask

   // Random operands biased towards corner values so carries, zero results
   // and zero divisors turn up often.
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(7))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return 32'($urandom_range(40));
         default: return $urandom();
      endcase
   endfunction

   initial begin
      req_type_t_type rq;
      int             phase;
      int             wait_cycles;
      failures      = 0;
      cycle_count   = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      fl_carry = 1'b0; fl_borrow = 1'b0; fl_overflow = 1'b0;
      fl_zero = 1'b0; fl_negative = 1'b0; fl_odd = 1'b0;

      // Directed table. Rows right after reset and at the operand extremes
      // carry a hand-worked response; the rest are left to the predictor.
      add_row(mk_req(OP_TEST, 32'h0, 32'h0, 1'b0), 1, mk_rsp(32'h0, 6'b000100));
      add_row(mk_req(OP_ADD, '1, 32'h1, 1'b0), 1, mk_rsp(32'h0, 6'b100100));
      add_row(mk_req(OP_ADD, '1, 32'h0, 1'b1), 1, mk_rsp(32'h0, 6'b100100));
      add_row(mk_req(OP_ADD, 32'h7FFF_FFFF, 32'h1, 1'b0), 1,
              mk_rsp(32'h8000_0000, 6'b001010));
      add_row(mk_req(OP_SUB, 32'h0, 32'h1, 1'b0), 1, mk_rsp('1, 6'b010011));
      add_row(mk_req(OP_SUB, 32'h0, '1, 1'b1), 1, mk_rsp(32'h0, 6'b010100));
      add_row(mk_req(OP_SUB, 32'h8000_0000, 32'h1, 1'b0), 0, '0);
      add_row(mk_req(OP_MUL, '1, '1, 1'b0), 0, '0);
      add_row(mk_req(OP_HMUL, '1, '1, 1'b1), 0, '0);
      add_row(mk_req(OP_DIV, 32'd1234, 32'h0, 1'b0), 1, mk_rsp('1, 6'b001011));
      add_row(mk_req(OP_MOD, 32'd1234, 32'h0, 1'b0), 1, mk_rsp(32'd1234, 6'b001000));
      add_row(mk_req(OP_LDIV, 32'd5, 32'h0, 1'b0), 1, mk_rsp('1, 6'b001011));
      add_row(mk_req(OP_LDIV, 32'd7, 32'd3, 1'b0), 0, '0);
      add_row(mk_req(OP_DIV, '1, 32'd7, 1'b0), 0, '0);
      add_row(mk_req(OP_AND, 32'hF0F0_F0F0, 32'h0FF0_0FF0, 1'b0), 0, '0);
      add_row(mk_req(OP_NAND, '1, '1, 1'b0), 0, '0);
      add_row(mk_req(OP_OR, 32'h1234_0000, 32'h0000_5678, 1'b0), 0, '0);
      add_row(mk_req(OP_XOR, 32'hAAAA_AAAA, '1, 1'b0), 0, '0);
      add_row(mk_req(OP_NOT, 32'h0, 32'h0, 1'b0), 0, '0);
      add_row(mk_req(OP_LSHF, 32'h1, 32'hFFFF_FFFF, 1'b0), 0, '0);
      add_row(mk_req(OP_RSHF, 32'h8000_0000, 32'd33, 1'b0), 0, '0);
      add_row(mk_req(OP_LROT, 32'h8000_0001, 32'h20, 1'b0), 0, '0);
      add_row(mk_req(OP_RROT, 32'h8000_0001, 32'h1, 1'b0), 0, '0);
      add_row(mk_req(5'd17, '1, '1, 1'b1), 0, '0);
      add_row(mk_req(5'd31, '1, '1, 1'b1), 0, '0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_table[i]) begin
         send_op(dir_table[i].req, dir_table[i].has_exp, dir_table[i].exp);
      end

      // Random part in three idling phases: slow sender and busy receiver,
      // then the reverse, then both at full rate.
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 73 : 0;
         recv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 29 : 0;
         repeat (NumRandom / 3) begin
            rq.req_type  = ($urandom_range(19) == 0) ? 5'($urandom_range(31, 17))
                                                    : 5'($urandom_range(16));
            rq.operand_a = pick_operand();
            rq.operand_b = pick_operand();
            rq.use_carry = 1'($urandom_range(1));
            send_op(rq, 1'b0, '0);
         end
      end
      req_valid <= 1'b0;

      wait_cycles = 0;
      while (pending_rsp.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      // Allow any stray response time to show up.
      repeat (100) @(posedge clock);

      if (failures == 0 && pending_rsp.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
